[hw/rtl/bbgs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbgs_pkg: shared types and constants
// Board limits, cell encoding and the request format between front and back.
// ----------------------------------------------------------------------------
package bbgs_pkg;

	localparam int MAX_COLS = 1024;
	localparam int MAX_ROWS = 1024;

	// column index into a line buffer
	localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	// effective board dimensions, 1..MAX
	localparam int COLS_W = $clog2(MAX_COLS + 1);
	localparam int ROWS_W = $clog2(MAX_ROWS + 1);
	// stream row position runs up to MAX_ROWS + 1 while draining
	localparam int ROW_W  = $clog2(MAX_ROWS + 2);

	// configuration registers
	localparam int CFG_W   = 11;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_BOARD_COLS = 1'b0;
	localparam logic REG_BOARD_ROWS = 1'b1;

	// input kinds
	localparam logic KIND_CELL  = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	// queue depths
	localparam int CQ_DEPTH = 4;
	localparam int OQ_DEPTH = 4;

	typedef enum logic [1:0] {
		ST_DEAD  = 2'd0,
		ST_DYING = 2'd1,
		ST_ALIVE = 2'd2,
		ST_KEEP  = 2'd3
	} cell_t;

	// one advance of the stencil, produced by the front
	typedef struct packed {
		logic [COL_W-1:0] col;
		cell_t            cell_in;
		logic             emit;      // this advance produces a result
		logic             top_ok;    // upper neighbor row lies on the board
		logic             bot_ok;    // lower neighbor row lies on the board
		logic             left_ok;   // left neighbor column lies on the board
		logic             right_ok;  // right neighbor column is used
		logic             last;      // result is the last cell of the board
	} cmd_t;

	typedef struct packed {
		cell_t next_state;
		logic  frame_last;
	} out_t;

endpackage

[hw/rtl/bbgs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbgs_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bbgs_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 1024
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hw/rtl/bbgs_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbgs_front: request intake and raster tracking
// Holds the board size registers, tracks the raster position, drops or
// restarts as the stream demands and tags each advance for the back end.
// ----------------------------------------------------------------------------
module bbgs_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bbgs_pkg::PADDR_W-1:0] paddr,
	input  logic [bbgs_pkg::PDATA_W-1:0] pwdata,
	output logic [bbgs_pkg::PDATA_W-1:0] prdata,
	input  logic                         push,
	output logic                         full,
	input  logic                         kind,
	input  logic [1:0]                   cell_state,
	output logic                         cq_push,
	output bbgs_pkg::cmd_t               cq_cmd,
	input  logic                         cq_full
);

	logic [bbgs_pkg::CFG_W-1:0]  cols_raw_q, rows_raw_q;
	logic [bbgs_pkg::COL_W-1:0]  col_q, c, col_nxt;
	logic [bbgs_pkg::ROW_W-1:0]  row_q, r, row_nxt;
	logic [bbgs_pkg::COLS_W-1:0] cols;
	logic [bbgs_pkg::ROWS_W-1:0] rows;
	logic [bbgs_pkg::ROW_W-1:0]  rows_x;
	logic cfg_we, all_in, restart, ignore, accept, start_e, norm_e, wrap;

	assign cfg_we = psel && penable && pwrite;

	// board size as used: zero counts as one, large values saturate
	always_comb begin
		if (cols_raw_q == '0)
			cols = bbgs_pkg::COLS_W'(1);
		else if (cols_raw_q > bbgs_pkg::MAX_COLS)
			cols = bbgs_pkg::COLS_W'(bbgs_pkg::MAX_COLS);
		else
			cols = bbgs_pkg::COLS_W'(cols_raw_q);
		if (rows_raw_q == '0)
			rows = bbgs_pkg::ROWS_W'(1);
		else if (rows_raw_q > bbgs_pkg::MAX_ROWS)
			rows = bbgs_pkg::ROWS_W'(bbgs_pkg::MAX_ROWS);
		else
			rows = bbgs_pkg::ROWS_W'(rows_raw_q);
	end

	assign rows_x = bbgs_pkg::ROW_W'(rows);

	always_comb begin
		if (paddr[2] == bbgs_pkg::REG_BOARD_ROWS)
			prdata = bbgs_pkg::PDATA_W'(rows_raw_q);
		else
			prdata = bbgs_pkg::PDATA_W'(cols_raw_q);
	end

	always_comb begin
		// every cell of the board is in: only flushes advance now
		all_in  = row_q >= rows_x;
		restart = (kind == bbgs_pkg::KIND_CELL) && all_in;
		ignore  = (kind == bbgs_pkg::KIND_FLUSH) && !all_in;
		accept  = push && !cq_full;
		cq_push = accept && !ignore;
		full    = cq_full;

		r = restart ? '0 : row_q;
		c = restart ? '0 : col_q;

		// row start releases the last cell of the row two above
		start_e = (c == '0) && (r >= bbgs_pkg::ROW_W'(2));
		norm_e  = (c != '0) && (r >= bbgs_pkg::ROW_W'(1));

		cq_cmd.col     = c;
		cq_cmd.cell_in = (kind == bbgs_pkg::KIND_FLUSH) ? bbgs_pkg::ST_DEAD
		                                               : bbgs_pkg::cell_t'(cell_state);
		cq_cmd.emit    = start_e || norm_e;
		if (start_e) begin
			cq_cmd.top_ok   = r >= bbgs_pkg::ROW_W'(3);
			cq_cmd.bot_ok   = r <= rows_x;
			cq_cmd.left_ok  = cols >= bbgs_pkg::COLS_W'(2);
			cq_cmd.right_ok = 1'b0;
		end else begin
			cq_cmd.top_ok   = r >= bbgs_pkg::ROW_W'(2);
			cq_cmd.bot_ok   = r < rows_x;
			cq_cmd.left_ok  = c >= bbgs_pkg::COL_W'(2);
			cq_cmd.right_ok = 1'b1;
		end
		cq_cmd.last = start_e && (r == rows_x + bbgs_pkg::ROW_W'(1));

		wrap = (bbgs_pkg::COLS_W'(c) + bbgs_pkg::COLS_W'(1)) == cols;
		if (cq_cmd.last) begin
			col_nxt = '0;
			row_nxt = '0;
		end else if (wrap) begin
			col_nxt = '0;
			row_nxt = r + bbgs_pkg::ROW_W'(1);
		end else begin
			col_nxt = c + bbgs_pkg::COL_W'(1);
			row_nxt = r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_raw_q <= bbgs_pkg::CFG_W'(64);
			rows_raw_q <= bbgs_pkg::CFG_W'(64);
			col_q      <= '0;
			row_q      <= '0;
		end else if (cfg_we) begin
			if (paddr[2] == bbgs_pkg::REG_BOARD_ROWS)
				rows_raw_q <= pwdata[bbgs_pkg::CFG_W-1:0];
			else
				cols_raw_q <= pwdata[bbgs_pkg::CFG_W-1:0];
			col_q <= '0;
			row_q <= '0;
		end else if (cq_push) begin
			col_q <= col_nxt;
			row_q <= row_nxt;
		end
	end

endmodule

[hw/rtl/bbgs_cmd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbgs_cmd_queue: request queue between front and back
// Small flop FIFO that lets intake and stencil stall independently.
// ----------------------------------------------------------------------------
module bbgs_cmd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bbgs_pkg::cmd_t din,
	output logic           full,
	input  logic           pop,
	output bbgs_pkg::cmd_t dout,
	output logic           empty
);

	localparam int PTR_W = $clog2(bbgs_pkg::CQ_DEPTH);
	localparam int CNT_W = $clog2(bbgs_pkg::CQ_DEPTH + 1);

	bbgs_pkg::cmd_t   mem_q [bbgs_pkg::CQ_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full    = cnt_q == CNT_W'(bbgs_pkg::CQ_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + PTR_W'(1);
			if (do_pop)
				rd_q <= rd_q + PTR_W'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

endmodule

[hw/rtl/bbgs_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbgs_back: line buffers, window and rule
// Reads the two row buffers, shifts the window, counts alive neighbors,
// applies the rule and queues results for the output side.
// ----------------------------------------------------------------------------
module bbgs_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cq_empty,
	input  bbgs_pkg::cmd_t cq_cmd,
	output logic           cq_pop,
	output logic           empty,
	input  logic           pop,
	output logic [1:0]     next_state,
	output logic           frame_last
);

	localparam int PTR_W = $clog2(bbgs_pkg::OQ_DEPTH);
	localparam int CNT_W = $clog2(bbgs_pkg::OQ_DEPTH + 1);

	bbgs_pkg::cmd_t   cmd_s1;
	logic             v_s1, fwd_s1;
	logic [3:0]       fwd_data_s1, rd_data, ram_rdata, wr_data;
	bbgs_pkg::cell_t  wl_q [3];
	bbgs_pkg::cell_t  wc_q [3];
	bbgs_pkg::cell_t  nc [3];
	logic [7:0]       alive;
	logic [3:0]       n_alive;
	bbgs_pkg::out_t   res;
	bbgs_pkg::out_t   oq_q [bbgs_pkg::OQ_DEPTH];
	logic [PTR_W-1:0] oq_wr_q, oq_rd_q;
	logic [CNT_W-1:0] oq_cnt_q;
	logic             issue, oq_push, oq_pop;

	// issue only with room guaranteed for the request still in flight
	always_comb begin
		issue = !cq_empty &&
		        ((CNT_W+1)'(oq_cnt_q) + (CNT_W+1)'(v_s1 && cmd_s1.emit)) <
		        (CNT_W+1)'(bbgs_pkg::OQ_DEPTH);
	end
	assign cq_pop = issue;

	// line buffer word: {row above, middle row}
	assign wr_data = {rd_data[1:0], cmd_s1.cell_in};

	bbgs_ram #(
		.WIDTH(4),
		.DEPTH(bbgs_pkg::MAX_COLS)
	) u_line_buf (
		.clk  (clk),
		.we   (v_s1),
		.waddr(cmd_s1.col),
		.wdata(wr_data),
		.raddr(cq_cmd.col),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			v_s1   <= issue;
			// one-column board: read and write hit the same word together
			fwd_s1 <= issue && v_s1 && (cq_cmd.col == cmd_s1.col);
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			cmd_s1 <= cq_cmd;
		end
		fwd_data_s1 <= wr_data;
	end

	always_comb begin
		rd_data = fwd_s1 ? fwd_data_s1 : ram_rdata;
		nc[0]   = bbgs_pkg::cell_t'(rd_data[3:2]);
		nc[1]   = bbgs_pkg::cell_t'(rd_data[1:0]);
		nc[2]   = cmd_s1.cell_in;

		alive[0] = cmd_s1.top_ok && cmd_s1.left_ok  && (wl_q[0] == bbgs_pkg::ST_ALIVE);
		alive[1] = cmd_s1.top_ok &&                    (wc_q[0] == bbgs_pkg::ST_ALIVE);
		alive[2] = cmd_s1.top_ok && cmd_s1.right_ok && (nc[0]   == bbgs_pkg::ST_ALIVE);
		alive[3] =                  cmd_s1.left_ok  && (wl_q[1] == bbgs_pkg::ST_ALIVE);
		alive[4] =                  cmd_s1.right_ok && (nc[1]   == bbgs_pkg::ST_ALIVE);
		alive[5] = cmd_s1.bot_ok && cmd_s1.left_ok  && (wl_q[2] == bbgs_pkg::ST_ALIVE);
		alive[6] = cmd_s1.bot_ok &&                    (wc_q[2] == bbgs_pkg::ST_ALIVE);
		alive[7] = cmd_s1.bot_ok && cmd_s1.right_ok && (nc[2]   == bbgs_pkg::ST_ALIVE);
		n_alive  = 4'($countones(alive));

		case (wc_q[1])
			bbgs_pkg::ST_DEAD:
				res.next_state = (n_alive == 4'd2) ? bbgs_pkg::ST_ALIVE : bbgs_pkg::ST_DEAD;
			bbgs_pkg::ST_DYING: res.next_state = bbgs_pkg::ST_DEAD;
			bbgs_pkg::ST_ALIVE: res.next_state = bbgs_pkg::ST_DYING;
			default:            res.next_state = wc_q[1];
		endcase
		res.frame_last = cmd_s1.last;
	end

	// window keeps the two columns left of the incoming one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				wl_q[i] <= bbgs_pkg::ST_DEAD;
				wc_q[i] <= bbgs_pkg::ST_DEAD;
			end
		end else if (v_s1) begin
			for (int i = 0; i < 3; i++) begin
				wl_q[i] <= wc_q[i];
				wc_q[i] <= nc[i];
			end
		end
	end

	// result queue
	assign oq_push    = v_s1 && cmd_s1.emit;
	assign empty      = oq_cnt_q == '0;
	assign oq_pop     = pop && !empty;
	assign next_state = oq_q[oq_rd_q].next_state;
	assign frame_last = oq_q[oq_rd_q].frame_last;

	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_q[oq_wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (oq_push)
				oq_wr_q <= oq_wr_q + PTR_W'(1);
			if (oq_pop)
				oq_rd_q <= oq_rd_q + PTR_W'(1);
			if (oq_push && !oq_pop)
				oq_cnt_q <= oq_cnt_q + CNT_W'(1);
			else if (oq_pop && !oq_push)
				oq_cnt_q <= oq_cnt_q - CNT_W'(1);
		end
	end

endmodule

[hw/rtl/brians_brain_generation_step_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brians_brain_generation_step_unit: streaming Brian's Brain generation step
// Cells enter in raster order and leave as the next generation in raster
// order.
//
// Input queue: push/full with kind and cell_state. kind selects a board cell
// or a flush tick; flushes feed dead cells below the board to drain the last
// row. A flush while cells are still missing is dropped; a cell while results
// are still pending starts a new board.
// Result queue: empty/pop with next_state and frame_last (last cell of board).
// Config: APB registers board_cols at 0x0 and board_rows at 0x4; a write
// restarts the board. Write only while idle.
// Throughput: one item per clock while the result queue has room. A cell's
// result is released by the item one row plus one cell later, then passes
// the request queue, line buffer read and result queue write to the ports.
// When pop stays low, up to four results and four requests are held, then full
// rises. Reset empties both queues and loads a 64 x 64 board; the line buffers
// need no clearing since stale columns are masked as off-board.
// ----------------------------------------------------------------------------
module brians_brain_generation_step_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bbgs_pkg::PADDR_W-1:0] paddr,
	input  logic [bbgs_pkg::PDATA_W-1:0] pwdata,
	output logic [bbgs_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	input  logic                         push,
	output logic                         full,
	input  logic                         kind,
	input  logic [1:0]                   cell_state,
	output logic                         empty,
	input  logic                         pop,
	output logic [1:0]                   next_state,
	output logic                         frame_last
);

	bbgs_pkg::cmd_t fq_cmd, bq_cmd;
	logic           cq_push, cq_full, cq_pop, cq_empty;

	assign pready = 1'b1;

	bbgs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.push      (push),
		.full      (full),
		.kind      (kind),
		.cell_state(cell_state),
		.cq_push   (cq_push),
		.cq_cmd    (fq_cmd),
		.cq_full   (cq_full)
	);

	bbgs_cmd_queue u_cmd_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cq_push),
		.din   (fq_cmd),
		.full  (cq_full),
		.pop   (cq_pop),
		.dout  (bq_cmd),
		.empty (cq_empty)
	);

	bbgs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cq_empty  (cq_empty),
		.cq_cmd    (bq_cmd),
		.cq_pop    (cq_pop),
		.empty     (empty),
		.pop       (pop),
		.next_state(next_state),
		.frame_last(frame_last)
	);

	// back end never pulls from an empty request queue
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cq_empty |-> !cq_pop)
		else $error("back end popped an empty request queue");

	// front end never pushes into a full request queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cq_full |-> !cq_push)
		else $error("front end pushed into a full request queue");

	// a request pushed into an idle queue is visible next cycle
	a_push_visible: assert property (@(posedge clk) disable iff (!arst_n)
		(cq_push && cq_empty) |=> !cq_empty)
		else $error("pushed request lost in the request queue");

endmodule
